@@ design/rolling_fourth_power_mean_core_defines.svh @@
// Assertion macros shared by the rolling fourth-power mean core.
`ifndef ROLLING_FOURTH_POWER_MEAN_CORE_DEFINES_SVH
`define ROLLING_FOURTH_POWER_MEAN_CORE_DEFINES_SVH

// Check that a condition holds in the same cycle as its trigger.
`define RFPM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define RFPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/rfpm_pkg.sv @@
// Types, widths and constants of the rolling fourth-power mean core.
package rfpm_pkg;

  // Field widths
  localparam int POWER_W    = 11;
  localparam int PERIOD_W   = 5;
  localparam int WLEN_W     = 5;
  localparam int WSUM_W     = 16;
  localparam int TOTAL_W    = 64;
  localparam int MEAN_W     = 15;
  localparam int ROOT_W     = 15;
  localparam int DUR_W      = 25;
  localparam int MUL_W      = 32;
  localparam int TERM_DROP  = 16;
  localparam int Q4_BITS    = 4;

  // Largest window sum: thirty full-scale samples
  localparam logic [WSUM_W-1:0] WSUM_MAX = 16'd61410;

  // Divider step counts
  localparam int DIV_STEP_W = 7;
  localparam logic [DIV_STEP_W-1:0] MEAN_STEPS  = 7'd20;
  localparam logic [DIV_STEP_W-1:0] TOTAL_STEPS = 7'd64;

  // Root search starts at this bit
  localparam logic [3:0] ROOT_TOP_BIT = 4'd14;

  // Window length floor(30 / period), zero for period zero
  localparam logic [WLEN_W-1:0] WINDOW_LUT [32] = '{
    5'd0,  5'd30, 5'd15, 5'd10, 5'd7, 5'd6, 5'd5, 5'd4,
    5'd3,  5'd3,  5'd3,  5'd2,  5'd2, 5'd2, 5'd2, 5'd2,
    5'd1,  5'd1,  5'd1,  5'd1,  5'd1, 5'd1, 5'd1, 5'd1,
    5'd1,  5'd1,  5'd1,  5'd1,  5'd1, 5'd1, 5'd1, 5'd0
  };

  // Divider request and status
  typedef struct packed {
    logic                  start;
    logic [DIV_STEP_W-1:0] steps;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

@@ design/rfpm_if.sv @@
// Handshake channels of the rolling fourth-power mean core.
interface rfpm_smp_if;
  logic                          valid;
  logic                          ready;
  logic [rfpm_pkg::POWER_W-1:0]  power_watts;
  logic                          last_sample;

  modport source (output valid, output power_watts, output last_sample, input ready);
  modport sink   (input valid, input power_watts, input last_sample, output ready);
endinterface

interface rfpm_res_if;
  logic                          valid;
  logic                          ready;
  logic [rfpm_pkg::ROOT_W-1:0]   iso_power_q4;
  logic [rfpm_pkg::DUR_W-1:0]    duration_s;
  logic                          valid_res;

  modport source (output valid, output iso_power_q4, output duration_s,
                  output valid_res, input ready);
  modport sink   (input valid, input iso_power_q4, input duration_s,
                  input valid_res, output ready);
endinterface

interface rfpm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [rfpm_pkg::PERIOD_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/rfpm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rfpm_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ design/rfpm_div.sv @@
// Restoring divider, one quotient bit per cycle, left-aligned dividend.
module rfpm_div #(
  parameter int DIVISOR_W = 20
) (
  input  logic                              clk,
  input  logic                              rst,
  input  rfpm_pkg::div_ctl_t                ctl,
  input  logic [rfpm_pkg::TOTAL_W-1:0]      dividend,
  input  logic [DIVISOR_W-1:0]              divisor,
  output rfpm_pkg::div_sts_t                sts,
  output logic [rfpm_pkg::TOTAL_W-1:0]      quotient
);

  logic [DIVISOR_W-1:0]            rem;
  logic [DIVISOR_W-1:0]            dvs;
  logic [rfpm_pkg::DIV_STEP_W-1:0] steps_left;
  logic                            running;
  logic                            done;
  logic [DIVISOR_W:0]              shifted;
  logic [DIVISOR_W:0]              trial;
  logic                            trial_ok;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    shifted  = {rem, quotient[rfpm_pkg::TOTAL_W-1]};
    trial    = shifted - {1'b0, dvs};
    trial_ok = ~trial[DIVISOR_W];
  end

  // Step the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        quotient   <= dividend;
        rem        <= '0;
        dvs        <= divisor;
        steps_left <= ctl.steps;
        running    <= 1'b1;
      end else if (running) begin
        quotient   <= {quotient[rfpm_pkg::TOTAL_W-2:0], trial_ok};
        rem        <= trial_ok ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
        steps_left <= steps_left - 1'b1;
        if (steps_left == rfpm_pkg::DIV_STEP_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = running;
  assign sts.done = done;

endmodule

@@ design/rolling_fourth_power_mean_core.sv @@
// Rolling 30 s fourth-power mean core: window, accumulation and final root.
// Throughput: one sample at a time. A sample with window length > 1 runs
//   the divider for the Q4 mean, two squarings and an add; with a shorter
//   window it is not accumulated. A last sample adds a divide of the total
//   by the count and a 15-bit root found one bit at a time.
// Reset (rst, synchronous): period 1, window, sums and count cleared at once.
`include "rolling_fourth_power_mean_core_defines.svh"

module rolling_fourth_power_mean_core #(
  parameter int WINDOW_MAX = 32,
  parameter int COUNT_BITS = 20
) (
  input  logic       clk,
  input  logic       rst,
  rfpm_smp_if.sink   smp,
  rfpm_res_if.source res,
  rfpm_cfg_if.sink   cfg
);

  localparam int POS_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CMP_W = (POS_W > rfpm_pkg::WLEN_W) ? POS_W : rfpm_pkg::WLEN_W;

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_READ  = 4'd1;
  localparam logic [3:0] S_DIVM  = 4'd2;
  localparam logic [3:0] S_SQ1   = 4'd3;
  localparam logic [3:0] S_SQ2   = 4'd4;
  localparam logic [3:0] S_ACC   = 4'd5;
  localparam logic [3:0] S_FINAL = 4'd6;
  localparam logic [3:0] S_DIVT  = 4'd7;
  localparam logic [3:0] S_ROOTA = 4'd8;
  localparam logic [3:0] S_ROOTB = 4'd9;
  localparam logic [3:0] S_ROOTC = 4'd10;
  localparam logic [3:0] S_DUR   = 4'd11;
  localparam logic [3:0] S_DURW  = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  logic [3:0]                        state;
  logic [rfpm_pkg::PERIOD_W-1:0]     period;
  logic [rfpm_pkg::WLEN_W-1:0]       wl;
  logic [POS_W-1:0]                  pos;
  logic [WINDOW_MAX-1:0]             ring_valid;
  logic [rfpm_pkg::WSUM_W-1:0]       wsum;
  logic [rfpm_pkg::TOTAL_W-1:0]      total;
  logic [COUNT_BITS-1:0]             count;
  logic [rfpm_pkg::POWER_W-1:0]      smp_p;
  logic                              smp_last;
  logic [rfpm_pkg::ROOT_W-1:0]       root;
  logic [3:0]                        bit_idx;
  logic [2*rfpm_pkg::MUL_W-1:0]      prod;
  logic                              out_valid;
  logic [rfpm_pkg::ROOT_W-1:0]       res_iso;
  logic [rfpm_pkg::DUR_W-1:0]        res_dur;
  logic                              res_vld;
  logic [rfpm_pkg::ROOT_W-1:0]       out_iso;
  logic [rfpm_pkg::DUR_W-1:0]        out_dur;
  logic                              out_vld;

  logic                              smp_fire;
  logic                              cfg_fire;
  logic                              out_free;
  logic                              count_full;
  logic [POS_W-1:0]                  pos_eff;
  logic [POS_W-1:0]                  pos_next;
  logic [rfpm_pkg::POWER_W-1:0]      ram_rdata;
  logic [rfpm_pkg::POWER_W-1:0]      old_p;
  logic [rfpm_pkg::WSUM_W:0]         sum_plus;
  logic [rfpm_pkg::WSUM_W-1:0]       sum_new;
  logic [rfpm_pkg::WLEN_W-1:0]       wl_cfg;
  logic [rfpm_pkg::ROOT_W-1:0]       trial_t;
  logic [rfpm_pkg::MUL_W-1:0]        mul_a;
  logic [rfpm_pkg::MUL_W-1:0]        mul_b;
  logic [rfpm_pkg::TOTAL_W:0]        total_sum;
  logic [rfpm_pkg::TOTAL_W-1:0]      div_dividend;
  logic [COUNT_BITS-1:0]             div_divisor;
  rfpm_pkg::div_ctl_t                div_ctl;
  rfpm_pkg::div_sts_t                div_sts;
  logic [rfpm_pkg::TOTAL_W-1:0]      div_q;

  // Handshakes
  assign smp.ready  = (state == S_IDLE) && !cfg.valid;
  assign cfg.ready  = (state == S_IDLE);
  assign smp_fire   = smp.valid && smp.ready;
  assign cfg_fire   = cfg.valid && cfg.ready;
  assign out_free   = !out_valid || res.ready;
  assign count_full = (count == '1);

  // Window length for a newly written period, capped at the ring depth
  always_comb begin
    wl_cfg = rfpm_pkg::WINDOW_LUT[cfg.data];
    if (int'(wl_cfg) > WINDOW_MAX) begin
      wl_cfg = rfpm_pkg::WLEN_W'(WINDOW_MAX);
    end
  end

  // Ring position, wrapped into the current window
  always_comb begin
    pos_eff  = (CMP_W'(pos) >= CMP_W'(wl)) ? '0 : pos;
    pos_next = ((CMP_W'(pos_eff) + CMP_W'(1)) >= CMP_W'(wl)) ? '0 : pos_eff + 1'b1;
  end

  // Window ring storage
  rfpm_ram #(
    .WIDTH (rfpm_pkg::POWER_W),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk   (clk),
    .we    (state == S_READ),
    .waddr (pos_eff),
    .wdata (smp_p),
    .raddr (pos_eff),
    .rdata (ram_rdata)
  );

  // Swap the oldest sample for the new one in the window sum
  always_comb begin
    old_p    = ring_valid[pos_eff] ? ram_rdata : '0;
    sum_plus = {1'b0, wsum} + (rfpm_pkg::WSUM_W+1)'(smp_p);
    sum_new  = (sum_plus >= (rfpm_pkg::WSUM_W+1)'(old_p)) ?
               rfpm_pkg::WSUM_W'(sum_plus - (rfpm_pkg::WSUM_W+1)'(old_p)) : '0;
  end

  // Divider requests: Q4 window mean, then total over count
  always_comb begin
    div_ctl.start = ((state == S_READ) && !count_full) ||
                    ((state == S_FINAL) && (count != '0));
    div_ctl.steps = (state == S_READ) ? rfpm_pkg::MEAN_STEPS : rfpm_pkg::TOTAL_STEPS;
    if (state == S_READ) begin
      div_dividend = {sum_new, {rfpm_pkg::Q4_BITS{1'b0}},
                      {(rfpm_pkg::TOTAL_W - rfpm_pkg::WSUM_W - rfpm_pkg::Q4_BITS){1'b0}}};
      div_divisor  = COUNT_BITS'(wl);
    end else begin
      div_dividend = total;
      div_divisor  = count;
    end
  end

  rfpm_div #(
    .DIVISOR_W (COUNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .sts      (div_sts),
    .quotient (div_q)
  );

  // Shared multiplier operands
  assign trial_t = root | (rfpm_pkg::ROOT_W'(1) << bit_idx);

  always_comb begin
    case (state)
      S_SQ1: begin
        mul_a = rfpm_pkg::MUL_W'(div_q[rfpm_pkg::MEAN_W-1:0]);
        mul_b = rfpm_pkg::MUL_W'(div_q[rfpm_pkg::MEAN_W-1:0]);
      end
      S_SQ2, S_ROOTB: begin
        mul_a = rfpm_pkg::MUL_W'(prod[2*rfpm_pkg::ROOT_W-1:0]);
        mul_b = rfpm_pkg::MUL_W'(prod[2*rfpm_pkg::ROOT_W-1:0]);
      end
      S_ROOTA: begin
        mul_a = rfpm_pkg::MUL_W'(trial_t);
        mul_b = rfpm_pkg::MUL_W'(trial_t);
      end
      S_DUR: begin
        mul_a = rfpm_pkg::MUL_W'(count);
        mul_b = rfpm_pkg::MUL_W'(period);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Register every product
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Saturating add of the dropped fourth power
  assign total_sum = {1'b0, total} +
                     (rfpm_pkg::TOTAL_W+1)'(prod[4*rfpm_pkg::MEAN_W-1:rfpm_pkg::TERM_DROP]);

  // Sequencer and accumulator state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      period     <= rfpm_pkg::PERIOD_W'(1);
      wl         <= (int'(rfpm_pkg::WINDOW_LUT[1]) > WINDOW_MAX) ?
                    rfpm_pkg::WLEN_W'(WINDOW_MAX) : rfpm_pkg::WINDOW_LUT[1];
      pos        <= '0;
      ring_valid <= '0;
      wsum       <= '0;
      total      <= '0;
      count      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cfg_fire) begin
            period     <= cfg.data;
            wl         <= wl_cfg;
            pos        <= '0;
            ring_valid <= '0;
            wsum       <= '0;
            total      <= '0;
            count      <= '0;
          end else if (smp_fire) begin
            smp_p    <= smp.power_watts;
            smp_last <= smp.last_sample;
            if (wl > rfpm_pkg::WLEN_W'(1)) begin
              state <= S_READ;
            end else if (smp.last_sample) begin
              state <= S_FINAL;
            end
          end
        end
        S_READ: begin
          wsum                <= sum_new;
          ring_valid[pos_eff] <= 1'b1;
          pos                 <= pos_next;
          if (!count_full) begin
            state <= S_DIVM;
          end else begin
            state <= smp_last ? S_FINAL : S_IDLE;
          end
        end
        S_DIVM: begin
          if (div_sts.done) begin
            state <= S_SQ1;
          end
        end
        S_SQ1: begin
          state <= S_SQ2;
        end
        S_SQ2: begin
          state <= S_ACC;
        end
        S_ACC: begin
          total <= total_sum[rfpm_pkg::TOTAL_W] ? '1 : total_sum[rfpm_pkg::TOTAL_W-1:0];
          count <= count + 1'b1;
          state <= smp_last ? S_FINAL : S_IDLE;
        end
        S_FINAL: begin
          if (count == '0) begin
            res_iso <= '0;
            res_dur <= '0;
            res_vld <= 1'b0;
            state   <= S_OUT;
          end else begin
            state <= S_DIVT;
          end
        end
        S_DIVT: begin
          if (div_sts.done) begin
            root    <= '0;
            bit_idx <= rfpm_pkg::ROOT_TOP_BIT;
            state   <= S_ROOTA;
          end
        end
        S_ROOTA: begin
          state <= S_ROOTB;
        end
        S_ROOTB: begin
          state <= S_ROOTC;
        end
        S_ROOTC: begin
          if ((prod >> rfpm_pkg::TERM_DROP) <= div_q) begin
            root <= trial_t;
          end
          if (bit_idx == '0) begin
            state <= S_DUR;
          end else begin
            bit_idx <= bit_idx - 1'b1;
            state   <= S_ROOTA;
          end
        end
        S_DUR: begin
          state <= S_DURW;
        end
        S_DURW: begin
          res_iso <= root;
          res_dur <= prod[rfpm_pkg::DUR_W-1:0];
          res_vld <= 1'b1;
          state   <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            pos        <= '0;
            ring_valid <= '0;
            wsum       <= '0;
            total      <= '0;
            count      <= '0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: load a finished result, drop it once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_OUT) && out_free) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_OUT) && out_free) begin
      out_iso <= res_iso;
      out_dur <= res_dur;
      out_vld <= res_vld;
    end
  end

  assign res.valid        = out_valid;
  assign res.iso_power_q4 = out_iso;
  assign res.duration_s   = out_dur;
  assign res.valid_res    = out_vld;

  // Checks
  `RFPM_ASSERT_NOW(a_mean_fits, state == S_SQ1, div_q[rfpm_pkg::TOTAL_W-1:rfpm_pkg::MEAN_W] == '0, "window mean wider than 15 bits")
  `RFPM_ASSERT_NOW(a_wsum_bound, state == S_IDLE, wsum <= rfpm_pkg::WSUM_MAX, "window sum above full scale")
  `RFPM_ASSERT_NOW(a_pos_in_window, state == S_IDLE && wl > rfpm_pkg::WLEN_W'(1), CMP_W'(pos) < CMP_W'(wl), "ring position outside window")
  `RFPM_ASSERT_NEXT(a_clear_after_result, state == S_OUT && out_free, count == '0 && total == '0 && wsum == '0, "state not cleared after result")

endmodule
